>>> hdl/bfla_pkg.sv
// ----------------------------------------------------------------------------
// Block free-list allocator package
// Shared widths, command and status codes for the allocator core.
// ----------------------------------------------------------------------------
package bfla_pkg;

    // Block count and derived widths
    localparam int MAX_BLOCKS = 1024;
    localparam int BLK_W      = $clog2(MAX_BLOCKS);
    localparam int CNT_W      = BLK_W + 1;

    typedef logic [BLK_W-1:0] blk_t;
    typedef logic [CNT_W-1:0] cnt_t;

    // Command codes
    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_FREE  = 1'b1;

    // Status codes
    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_FULL = 2'd1;
    localparam logic [1:0] ST_BAD  = 2'd2;

    // Limit that applies: smaller of the disk size and the table size
    function automatic cnt_t usable_limit(input cnt_t disk_blocks);
        cnt_t lim;
        lim = disk_blocks;
        if (disk_blocks > cnt_t'(MAX_BLOCKS))
        begin
            lim = cnt_t'(MAX_BLOCKS);
        end
        return lim;
    endfunction

endpackage

>>> hdl/block_free_list_allocator_core.sv
// ----------------------------------------------------------------------------
// Block free-list allocator core
// Hands out and takes back storage blocks; freed blocks are reused oldest
// first from a linked list held in RAM, fresh ones come from a bump pointer.
// ----------------------------------------------------------------------------
// Usage:
//   Input stream (s_*): one word per request. s_tuser carries the command
//   (0 allocate, 1 free), s_tdata the block to free (ignored on allocate).
//   Output stream (m_*): exactly one word per request, in order, carrying
//   the granted block (0 unless an allocate succeeded) and a status:
//   0 ok, 1 disk full, 2 bad block index on free.
//   cfg_we/cfg_wdata set the disk size (blocks including reserved block 0);
//   write it only while no request is in flight.
// Sequencing:
//   One request at a time. Allocate from the bump pointer, a rejected
//   request and a free onto an empty list are handled in S_IDLE; allocate
//   from the free list adds S_POP (registered RAM read of the head link),
//   a free onto a non-empty list adds S_LINK (two link writes on the single
//   RAM write port). The result goes to an output register; the next request
//   is taken while it waits. If the receiver stalls with a result still
//   held, the following result parks and s_tready stays low until it moves.
// Reset:
//   Empty free list, bump pointer 1, disk size 1024. The link RAM is not
//   cleared; a link is only ever read after a free has written it.
// ----------------------------------------------------------------------------
module block_free_list_allocator_core (
    input  logic        clk,
    input  logic        rst_n,
    // Configuration: disk_blocks
    input  logic        cfg_we,
    input  logic [10:0] cfg_wdata,
    // Request stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,    // [9:0] block_index, [15:10] zero
    input  logic [0:0]  s_tuser,    // [0] cmd
    // Result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata     // [9:0] granted_block, [11:10] status, [15:12] zero
);

    // State codes
    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_POP  = 2'd1;
    localparam logic [1:0] S_LINK = 2'd2;
    localparam logic [1:0] S_EMIT = 2'd3;

    logic [1:0]    state_reg, state_next;
    bfla_pkg::blk_t head_reg, head_next;
    bfla_pkg::blk_t tail_reg, tail_next;
    bfla_pkg::cnt_t bump_reg, bump_next;
    bfla_pkg::cnt_t disk_reg, disk_next;
    bfla_pkg::blk_t link_addr_reg, link_addr_next;
    bfla_pkg::blk_t link_data_reg, link_data_next;
    bfla_pkg::blk_t res_blk_reg, res_blk_next;
    logic [1:0]    res_st_reg, res_st_next;
    logic          out_valid_reg, out_valid_next;
    bfla_pkg::blk_t out_blk_reg, out_blk_next;
    logic [1:0]    out_st_reg, out_st_next;

    // Datapath signals
    bfla_pkg::cnt_t lim;
    bfla_pkg::blk_t req_blk;
    logic          out_free;
    logic          res_valid;
    bfla_pkg::blk_t res_blk;
    logic [1:0]    res_st;
    logic          ram_we;
    bfla_pkg::blk_t ram_waddr;
    bfla_pkg::blk_t ram_wdata;
    bfla_pkg::blk_t ram_rdata;

    // Link memory: next_link per block
    bfla_ram #(
        .WIDTH (bfla_pkg::BLK_W),
        .DEPTH (bfla_pkg::MAX_BLOCKS)
    ) u_link_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (head_reg),
        .rdata (ram_rdata)
    );

    assign lim      = bfla_pkg::usable_limit(disk_reg);
    assign req_blk  = s_tdata[bfla_pkg::BLK_W-1:0];
    assign out_free = !out_valid_reg || m_tready;
    assign s_tready = (state_reg == S_IDLE);

    // Ports
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'd0, out_st_reg, out_blk_reg};

    // Next-state and datapath logic
    always_comb
    begin
        state_next     = state_reg;
        head_next      = head_reg;
        tail_next      = tail_reg;
        bump_next      = bump_reg;
        disk_next      = disk_reg;
        link_addr_next = link_addr_reg;
        link_data_next = link_data_reg;
        res_blk_next   = res_blk_reg;
        res_st_next    = res_st_reg;
        out_valid_next = out_valid_reg && !m_tready;
        out_blk_next   = out_blk_reg;
        out_st_next    = out_st_reg;
        res_valid      = 1'b0;
        res_blk        = '0;
        res_st         = bfla_pkg::ST_OK;
        ram_we         = 1'b0;
        ram_waddr      = '0;
        ram_wdata      = '0;

        if (cfg_we)
        begin
            disk_next = cfg_wdata;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    if (s_tuser[0] == bfla_pkg::CMD_ALLOC)
                    begin
                        if (head_reg != '0)
                        begin
                            // head link read is under way
                            state_next = S_POP;
                        end
                        else if (bump_reg < lim)
                        begin
                            res_valid = 1'b1;
                            res_blk   = bump_reg[bfla_pkg::BLK_W-1:0];
                            bump_next = bump_reg + bfla_pkg::cnt_t'(1);
                        end
                        else
                        begin
                            res_valid = 1'b1;
                            res_st    = bfla_pkg::ST_FULL;
                        end
                    end
                    else
                    begin
                        if (req_blk == '0 || {1'b0, req_blk} >= lim
                            || {1'b0, req_blk} >= bump_reg)
                        begin
                            res_valid = 1'b1;
                            res_st    = bfla_pkg::ST_BAD;
                        end
                        else
                        begin
                            // clear the freed block's link, make it the tail
                            ram_we    = 1'b1;
                            ram_waddr = req_blk;
                            tail_next = req_blk;
                            if (head_reg == '0)
                            begin
                                head_next = req_blk;
                                res_valid = 1'b1;
                            end
                            else
                            begin
                                link_addr_next = tail_reg;
                                link_data_next = req_blk;
                                state_next     = S_LINK;
                            end
                        end
                    end
                end
            end

            S_POP:
            begin
                res_valid = 1'b1;
                res_blk   = head_reg;
                head_next = ram_rdata;
                if (ram_rdata == '0)
                begin
                    tail_next = '0;
                end
            end

            S_LINK:
            begin
                // old tail points to the new block
                ram_we    = 1'b1;
                ram_waddr = link_addr_reg;
                ram_wdata = link_data_reg;
                res_valid = 1'b1;
            end

            S_EMIT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_blk_next   = res_blk_reg;
                    out_st_next    = res_st_reg;
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // Hand the result to the output register, or park it
        if (res_valid)
        begin
            if (out_free)
            begin
                out_valid_next = 1'b1;
                out_blk_next   = res_blk;
                out_st_next    = res_st;
                state_next     = S_IDLE;
            end
            else
            begin
                res_blk_next = res_blk;
                res_st_next  = res_st;
                state_next   = S_EMIT;
            end
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            head_reg      <= '0;
            tail_reg      <= '0;
            bump_reg      <= bfla_pkg::cnt_t'(1);
            disk_reg      <= bfla_pkg::cnt_t'(1024);
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            bump_reg      <= bump_next;
            disk_reg      <= disk_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        link_addr_reg <= link_addr_next;
        link_data_reg <= link_data_next;
        res_blk_reg   <= res_blk_next;
        res_st_reg    <= res_st_next;
        out_blk_reg   <= out_blk_next;
        out_st_reg    <= out_st_next;
    end

`ifndef SYNTHESIS
    // An empty list has no tail
    a_empty_tail: assert property (@(posedge clk) disable iff (!rst_n)
        head_reg == '0 |-> tail_reg == '0)
        else $error("free list empty but tail set");

    // Bump pointer stays within 1..MAX_BLOCKS
    a_bump_range: assert property (@(posedge clk) disable iff (!rst_n)
        bump_reg != '0 && bump_reg <= bfla_pkg::cnt_t'(bfla_pkg::MAX_BLOCKS))
        else $error("bump pointer out of range");

    // A rejected request never grants a block
    a_no_grant_on_err: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[11:10] != bfla_pkg::ST_OK |-> m_tdata[9:0] == '0)
        else $error("block granted with error status");

    // Link RAM is only written while taking a free or linking the old tail
    a_write_state: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> (state_reg == S_IDLE && s_tvalid) || state_reg == S_LINK)
        else $error("unexpected link RAM write");
`endif

endmodule

>>> hdl/bfla_ram.sv
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module bfla_ram #(
    parameter int WIDTH = 10,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

>>> tb/bfla_grant_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Block free-list allocator grant checker
// Watches the request, result and configuration ports of the allocator core.
// It keeps its own copy of the free list, the bump pointer and the disk size,
// predicts the grant for every accepted request word and compares each result
// word, field by field, with the oldest prediction still waiting.
// ----------------------------------------------------------------------------
module bfla_grant_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [10:0] cfg_wdata,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [15:0] s_tdata,    // [9:0] block_index, [15:10] zero
    input  logic [0:0]  s_tuser,    // [0] cmd
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [15:0] m_tdata,    // [9:0] granted_block, [11:10] status, [15:12] zero
    output int          errors,
    output int          outstanding
);

    typedef struct packed {
        bfla_pkg::blk_t granted;
        logic [1:0]     status;
    } grant_t;

    // Shadow allocator state
    bfla_pkg::blk_t link_ram [bfla_pkg::MAX_BLOCKS];
    bfla_pkg::blk_t head_blk;
    bfla_pkg::blk_t tail_blk;
    bfla_pkg::cnt_t bump_blk;
    bfla_pkg::cnt_t disk_size;
    grant_t         grant_q [$];

    // Grant for one request; updates the shadow state
    function automatic grant_t predict_grant(input logic cmd, input bfla_pkg::blk_t blk);
        grant_t         g;
        bfla_pkg::cnt_t lim;
        g.granted = '0;
        g.status  = bfla_pkg::ST_OK;
        lim = (disk_size > bfla_pkg::cnt_t'(bfla_pkg::MAX_BLOCKS))
            ? bfla_pkg::cnt_t'(bfla_pkg::MAX_BLOCKS) : disk_size;
        if (cmd == bfla_pkg::CMD_ALLOC)
        begin
            if (head_blk != '0)
            begin
                // oldest freed block first; empty list clears the tail too
                g.granted = head_blk;
                head_blk  = link_ram[head_blk];
                if (head_blk == '0)
                begin
                    tail_blk = '0;
                end
            end
            else if (bump_blk < lim)
            begin
                g.granted = bfla_pkg::blk_t'(bump_blk);
                bump_blk  = bump_blk + bfla_pkg::cnt_t'(1);
            end
            else
            begin
                g.status = bfla_pkg::ST_FULL;
            end
        end
        else
        begin
            if (blk == '0 || bfla_pkg::cnt_t'(blk) >= lim
                || bfla_pkg::cnt_t'(blk) >= bump_blk)
            begin
                g.status = bfla_pkg::ST_BAD;
            end
            else
            begin
                // append at tail; a double free links the block again
                link_ram[blk] = '0;
                if (head_blk == '0)
                begin
                    head_blk = blk;
                end
                else
                begin
                    link_ram[tail_blk] = blk;
                end
                tail_blk = blk;
            end
        end
        return g;
    endfunction

    // Compare result words, then log new requests and register writes
    always @(posedge clk or negedge rst_n)
    begin
        grant_t got;
        grant_t want;
        if (!rst_n)
        begin
            head_blk  = '0;
            tail_blk  = '0;
            bump_blk  = bfla_pkg::cnt_t'(1);
            disk_size = bfla_pkg::cnt_t'(1024);
            errors    = 0;
            grant_q.delete();
            outstanding <= 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                got.granted = m_tdata[9:0];
                got.status  = m_tdata[11:10];
                if (grant_q.size() == 0)
                begin
                    errors++;
                    $display("%0t: unexpected result word, expected none, actual %h",
                             $time, m_tdata);
                end
                else
                begin
                    want = grant_q.pop_front();
                    if (got.granted !== want.granted)
                    begin
                        errors++;
                        $display("%0t: granted_block mismatch, expected %0d, actual %0d",
                                 $time, want.granted, got.granted);
                    end
                    if (got.status !== want.status)
                    begin
                        errors++;
                        $display("%0t: status mismatch, expected %0d, actual %0d",
                                 $time, want.status, got.status);
                    end
                end
            end
            if (s_tvalid && s_tready)
            begin
                grant_q.push_back(predict_grant(s_tuser[0], s_tdata[9:0]));
            end
            if (cfg_we)
            begin
                disk_size = cfg_wdata;
            end
            outstanding <= grant_q.size();
        end
    end

endmodule

>>> tb/tb_block_free_list_allocator_core.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Block free-list allocator core testbench
// Drives request words through a short directed sequence and then random
// phases at several disk sizes, with random idling on both streams and one
// long receiver hold-off. Checking is done by the grant checker beside the
// core; this module gives the verdict.
// ----------------------------------------------------------------------------
module tb_block_free_list_allocator_core;

    localparam int CYCLE_LIMIT = 200000;
    localparam int HOLD_CYCLES = 300;

    logic        clk;
    logic        rst_n     = 1'b0;
    logic        cfg_we    = 1'b0;
    logic [10:0] cfg_wdata = '0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata   = '0;    // [9:0] block_index, [15:10] zero
    logic [0:0]  s_tuser   = '0;    // [0] cmd
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [15:0] m_tdata;           // [9:0] granted_block, [11:10] status, [15:12] zero
    int          errors;
    int          outstanding;

    // Flags shared between stimulus and receiver, and the run-limit cycle count
    bit          quiet     = 1'b0;
    bit          stall_req = 1'b0;
    int          cycles    = 0;

    block_free_list_allocator_core DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    bfla_grant_checker u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_wdata   (cfg_wdata),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .errors      (errors),
        .outstanding (outstanding)
    );

    // Clock
    initial
    begin
        clk = 1'b0;
        forever
        begin
            #5 clk = ~clk;
        end
    end

    // Run limit
    initial
    begin
        forever
        begin
            @(posedge clk);
            cycles++;
            if (cycles >= CYCLE_LIMIT)
            begin
                $display("*** FAILED ***");
                $finish;
            end
        end
    end

    // Receiver: random back-pressure, one long hold-off on request
    initial
    begin
        int hold_left;
        hold_left = 0;
        forever
        begin
            @(posedge clk);
            if (stall_req)
            begin
                stall_req = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                m_tready <= 1'b0;
            end
            else if (quiet)
            begin
                m_tready <= 1'b1;
            end
            else
            begin
                m_tready <= ($urandom_range(0, 99) >= 33);
            end
        end
    end

    // One request word, with random gaps before it
    task automatic send_word(input logic cmd, input bfla_pkg::blk_t blk);
        while (!quiet && $urandom_range(0, 99) < 33)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {6'd0, blk};
        s_tuser  <= cmd;
        @(posedge clk);
        while (!s_tready)
        begin
            @(posedge clk);
        end
    endtask

    // Drop valid and wait until every predicted word has come back
    task automatic settle();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
        begin
            @(posedge clk);
        end
        repeat (4) @(posedge clk);
    endtask

    task automatic write_disk(input int blocks);
        settle();
        cfg_wdata <= 11'(blocks);
        cfg_we    <= 1'b1;
        @(posedge clk);
        cfg_we    <= 1'b0;
        @(posedge clk);
    endtask

    // Random phase at one disk size; frees mostly aim at in-range blocks.
    // The hold-off starts once the disk size is set, while words are offered.
    task automatic run_phase(input int blocks, input int n_items, input bit hold);
        int             lim;
        int             alloc_pct;
        int             r;
        logic           cmd;
        bfla_pkg::blk_t blk;
        write_disk(blocks);
        if (hold)
        begin
            stall_req = 1'b1;
        end
        lim = (blocks > bfla_pkg::MAX_BLOCKS) ? bfla_pkg::MAX_BLOCKS : blocks;
        alloc_pct = $urandom_range(35, 65);
        repeat (n_items)
        begin
            cmd = ($urandom_range(0, 99) < alloc_pct) ? bfla_pkg::CMD_ALLOC
                                                      : bfla_pkg::CMD_FREE;
            blk = bfla_pkg::blk_t'($urandom);
            if (cmd == bfla_pkg::CMD_FREE && lim >= 2)
            begin
                r = $urandom_range(0, 99);
                if (r < 70)
                begin
                    blk = bfla_pkg::blk_t'($urandom_range(1, lim - 1));
                end
                else if (r < 80)
                begin
                    blk = '0;
                end
                else if (r < 90)
                begin
                    blk = bfla_pkg::blk_t'(lim - $urandom_range(0, 1));
                end
            end
            send_word(cmd, blk);
        end
    endtask

    // Stimulus and verdict
    initial
    begin
        int disks [14];
        disks = '{6, 12, 2, 20, 0, 30, 1, 3, 2047, 50, 1024, 16, 64, 9};

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: four-block disk
        write_disk(4);
        send_word(bfla_pkg::CMD_FREE,  10'd0);       // null block
        send_word(bfla_pkg::CMD_FREE,  10'd1);       // never handed out
        send_word(bfla_pkg::CMD_ALLOC, 10'd0);
        send_word(bfla_pkg::CMD_ALLOC, 10'd1023);
        send_word(bfla_pkg::CMD_ALLOC, 10'd0);
        send_word(bfla_pkg::CMD_ALLOC, 10'd0);       // disk full
        send_word(bfla_pkg::CMD_FREE,  10'd3);       // onto empty list
        send_word(bfla_pkg::CMD_FREE,  10'd1);       // onto non-empty list
        send_word(bfla_pkg::CMD_FREE,  10'd4);       // at the limit
        send_word(bfla_pkg::CMD_FREE,  10'd1023);
        send_word(bfla_pkg::CMD_ALLOC, 10'd0);       // oldest first
        send_word(bfla_pkg::CMD_ALLOC, 10'd0);       // last block popped
        send_word(bfla_pkg::CMD_FREE,  10'd2);

        // Shrink below a listed block: it is still handed out
        write_disk(2);
        send_word(bfla_pkg::CMD_ALLOC, 10'd0);
        send_word(bfla_pkg::CMD_ALLOC, 10'd0);
        send_word(bfla_pkg::CMD_FREE,  10'd3);

        // Tiny disk
        write_disk(0);
        send_word(bfla_pkg::CMD_ALLOC, 10'd0);

        // Double free links the block again
        write_disk(4);
        send_word(bfla_pkg::CMD_FREE,  10'd2);
        send_word(bfla_pkg::CMD_FREE,  10'd2);
        send_word(bfla_pkg::CMD_ALLOC, 10'd0);
        send_word(bfla_pkg::CMD_ALLOC, 10'd0);

        // Random phases
        for (int p = 0; p < 14; p++)
        begin
            quiet = (p == 5);
            run_phase(disks[p], 50, p == 3);
        end
        quiet = 1'b0;

        settle();
        repeat (10) @(posedge clk);
        if (errors == 0 && outstanding == 0)
        begin
            $display("*** PASSED ***");
        end
        else
        begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
